// ----- hdl/gcd_pkg.sv -----
// Shared constants and the CORDIC angle table for the great-circle distance core.
// Depends on nothing; used by great_circle_distance_core.
package gcd_pkg;

   // Input angles: degrees * 2^16. Internal CORDIC angles: degrees * 2^24.
   localparam int IN_HALF    = 180 * 65536;
   localparam int IN_QUARTER = 90 * 65536;
   localparam longint IN_FULL = 360 * 65536;
   localparam int Z_SHIFT    = 8;
   localparam longint Z_DEG  = 64'd16777216;
   localparam longint GAIN_Q30 = 64'd652032874;
   localparam longint OUT_MAX  = 64'd4194303;

   // Datapath widths
   localparam int AW = 27;   // reduced input angle
   localparam int XW = 34;   // CORDIC x / y, Q30 with headroom
   localparam int ZW = 34;   // CORDIC angle accumulator
   localparam int PW = 2 * XW;
   localparam int DW = 40;   // distance product

   function automatic logic [31:0] atan_deg(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'd754974720;
         5'd1:  r = 32'd445687602;
         5'd2:  r = 32'd235489088;
         5'd3:  r = 32'd119537938;
         5'd4:  r = 32'd60000934;
         5'd5:  r = 32'd30029717;
         5'd6:  r = 32'd15018523;
         5'd7:  r = 32'd7509720;
         5'd8:  r = 32'd3754917;
         5'd9:  r = 32'd1877466;
         5'd10: r = 32'd938734;
         5'd11: r = 32'd469367;
         5'd12: r = 32'd234684;
         5'd13: r = 32'd117342;
         5'd14: r = 32'd58671;
         5'd15: r = 32'd29335;
         5'd16: r = 32'd14668;
         5'd17: r = 32'd7334;
         5'd18: r = 32'd3667;
         5'd19: r = 32'd1833;
         5'd20: r = 32'd917;
         5'd21: r = 32'd458;
         5'd22: r = 32'd229;
         5'd23: r = 32'd115;
         5'd24: r = 32'd57;
         5'd25: r = 32'd29;
         5'd26: r = 32'd14;
         5'd27: r = 32'd7;
         5'd28: r = 32'd4;
         5'd29: r = 32'd2;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/great_circle_distance_core.sv -----
// Great-circle distance core: law of cosines with pipelined CORDIC, multiply and square root.
// Depends on gcd_pkg.

// Accepts one position pair per clock unless stalled and returns one distance per item, in
// order, through the input register, angle reduction, fold, CORDIC_STAGES rotation stages
// for the three sin/cos pairs, a sign fix, four multiply / round stages, two stages forming
// 1 - c^2, ANGLE_FRAC_BITS + 1 square-root stages (one root bit each), a quadrant stage and
// CORDIC_STAGES vectoring stages for the arc cosine, a clamp stage and the output register.
// A result-side stall with rsp_valid high freezes the whole pipeline; req_stall follows it.
// The cosine argument is clamped to [-1, 1], so equal points give 0 nm and
// antipodal points give 10800 nm; distances saturate at the field maximum.
module great_circle_distance_core #(
   parameter int ANGLE_FRAC_BITS = 16,
   parameter int DIST_FRAC_BITS  = 8,
   parameter int CORDIC_STAGES   = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_lat_a,
   input  logic signed [24:0] req_lon_a,
   input  logic signed [23:0] req_lat_b,
   input  logic signed [24:0] req_lon_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [21:0]        rsp_dist_nm
);

   localparam int A  = ANGLE_FRAC_BITS;
   localparam int N  = CORDIC_STAGES;
   localparam int CW = A + 2;
   localparam int VW = 2 * A + 2;
   localparam int S  = A + 1;
   localparam int AW = gcd_pkg::AW;
   localparam int XW = gcd_pkg::XW;
   localparam int ZW = gcd_pkg::ZW;
   localparam int PW = gcd_pkg::PW;
   localparam int DW = gcd_pkg::DW;

   // valid bit of the output register
   localparam int P_OUT = 2 * N + A + 13;

   logic en;
   logic [P_OUT:0] vld_ff;

   assign en        = !(vld_ff[P_OUT] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[P_OUT];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[P_OUT-1:0], req_valid};
      end
   end

   // ---- input register
   logic signed [AW-1:0] in_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         in_ff[0] <= AW'(req_lat_a);
         in_ff[1] <= AW'(req_lat_b);
         in_ff[2] <= AW'(req_lon_a) - AW'(req_lon_b);
      end
   end

   // ---- reduce longitude difference into [-180, 180)
   logic signed [AW-1:0] red_ff [3];
   logic signed [AW-1:0] red_in;
   always_comb begin
      red_in = in_ff[2];
      if (in_ff[2] >= AW'(gcd_pkg::IN_HALF)) begin
         red_in = in_ff[2] - AW'(gcd_pkg::IN_FULL);
      end else if (in_ff[2] < -AW'(gcd_pkg::IN_HALF)) begin
         red_in = in_ff[2] + AW'(gcd_pkg::IN_FULL);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         red_ff[0] <= in_ff[0];
         red_ff[1] <= in_ff[1];
         red_ff[2] <= red_in;
      end
   end

   // ---- rotation CORDIC for the three angles; index 0 is the folded start
   logic signed [XW-1:0] rx_ff [3][N+1];
   logic signed [XW-1:0] ry_ff [3][N+1];
   logic signed [ZW-1:0] rz_ff [3][N+1];
   logic                 rn_ff [3][N+1];

   for (genvar j = 0; j < 3; j++) begin : g_ang
      logic signed [AW-1:0] fold_in;
      logic                 neg_in;
      always_comb begin
         fold_in = red_ff[j];
         neg_in  = 1'b0;
         if (red_ff[j] > AW'(gcd_pkg::IN_QUARTER)) begin
            fold_in = red_ff[j] - AW'(gcd_pkg::IN_HALF);
            neg_in  = 1'b1;
         end else if (red_ff[j] < -AW'(gcd_pkg::IN_QUARTER)) begin
            fold_in = red_ff[j] + AW'(gcd_pkg::IN_HALF);
            neg_in  = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[j][0] <= XW'(gcd_pkg::GAIN_Q30);
            ry_ff[j][0] <= '0;
            rz_ff[j][0] <= ZW'(fold_in) <<< gcd_pkg::Z_SHIFT;
            rn_ff[j][0] <= neg_in;
         end
      end

      for (genvar k = 0; k < N; k++) begin : g_rot
         localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_deg(5'(k)));
         always_ff @(posedge clock) begin
            if (en) begin
               if (rz_ff[j][k] >= 0) begin
                  rx_ff[j][k+1] <= rx_ff[j][k] - (ry_ff[j][k] >>> k);
                  ry_ff[j][k+1] <= ry_ff[j][k] + (rx_ff[j][k] >>> k);
                  rz_ff[j][k+1] <= rz_ff[j][k] - ATAN;
               end else begin
                  rx_ff[j][k+1] <= rx_ff[j][k] + (ry_ff[j][k] >>> k);
                  ry_ff[j][k+1] <= ry_ff[j][k] - (rx_ff[j][k] >>> k);
                  rz_ff[j][k+1] <= rz_ff[j][k] + ATAN;
               end
               rn_ff[j][k+1] <= rn_ff[j][k];
            end
         end
      end
   end

   // ---- sign fix: sin/cos of lat_a, lat_b, cos of dlon
   logic signed [XW-1:0] sa_ff, ca_ff, sb_ff, cb_ff, cd_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= rn_ff[0][N] ? -ry_ff[0][N] : ry_ff[0][N];
         ca_ff <= rn_ff[0][N] ? -rx_ff[0][N] : rx_ff[0][N];
         sb_ff <= rn_ff[1][N] ? -ry_ff[1][N] : ry_ff[1][N];
         cb_ff <= rn_ff[1][N] ? -rx_ff[1][N] : rx_ff[1][N];
         cd_ff <= rn_ff[2][N] ? -rx_ff[2][N] : rx_ff[2][N];
      end
   end

   // ---- products
   logic signed [PW-1:0] m1_p1_ff, m1_p2_ff, m2_p1_ff, m3_p1_ff, m3_p3_ff;
   logic signed [XW-1:0] m1_cd_ff, m2_q_ff, m2_cd_ff;
   logic signed [PW-1:0] m2_q_in;
   assign m2_q_in = m1_p2_ff >>> 30;
   always_ff @(posedge clock) begin
      if (en) begin
         m1_p1_ff <= PW'(sa_ff) * PW'(sb_ff);
         m1_p2_ff <= PW'(ca_ff) * PW'(cb_ff);
         m1_cd_ff <= cd_ff;
         m2_p1_ff <= m1_p1_ff;
         m2_q_ff  <= m2_q_in[XW-1:0];
         m2_cd_ff <= m1_cd_ff;
         m3_p1_ff <= m2_p1_ff;
         m3_p3_ff <= PW'(m2_q_ff) * PW'(m2_cd_ff);
      end
   end

   // ---- cosine argument: round half up, clamp to [-1, 1]
   localparam logic signed [PW-1:0] ONE_P = PW'(1) <<< A;
   logic signed [PW-1:0] sum_in, cw_in;
   logic signed [CW-1:0] c_ff, c5_ff, c6_ff;
   assign sum_in = m3_p1_ff + m3_p3_ff + (PW'(1) <<< (59 - A));
   always_comb begin
      cw_in = sum_in >>> (60 - A);
      if (cw_in > ONE_P) begin
         cw_in = ONE_P;
      end else if (cw_in < -ONE_P) begin
         cw_in = -ONE_P;
      end
   end

   logic signed [2*CW-1:0] c2_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         c_ff  <= cw_in[CW-1:0];
         c2_ff <= (2*CW)'(c_ff) * (2*CW)'(c_ff);
         c5_ff <= c_ff;
      end
   end

   // ---- square root of 1 - c^2, one root bit per stage
   logic [VW-1:0] rem_ff [S+1];
   logic [A:0]    root_ff [S+1];
   logic signed [CW-1:0] sc_ff [S+1];
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= (VW'(1) << (2 * A)) - c2_ff[VW-1:0];
         root_ff[0] <= '0;
         sc_ff[0]   <= c5_ff;
      end
   end
   for (genvar g = 0; g < S; g++) begin : g_sqrt
      localparam int K = A - g;
      logic [VW-1:0] trial;
      assign trial = (VW'(root_ff[g]) << (K + 1)) + (VW'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[g] >= trial) begin
               rem_ff[g+1]  <= rem_ff[g] - trial;
               root_ff[g+1] <= root_ff[g] | ((A+1)'(1) << K);
            end else begin
               rem_ff[g+1]  <= rem_ff[g];
               root_ff[g+1] <= root_ff[g];
            end
            sc_ff[g+1] <= sc_ff[g];
         end
      end
   end
   assign c6_ff = sc_ff[S];

   // ---- vectoring CORDIC: atan2(s, c)
   logic signed [XW-1:0] vx_ff [N+1];
   logic signed [XW-1:0] vy_ff [N+1];
   logic signed [ZW-1:0] vz_ff [N+1];
   logic                 vs_ff [N+1];   // s is zero
   logic                 vp_ff [N+1];   // c is positive
   logic signed [XW-1:0] vx_in, vy_in;
   always_comb begin
      vx_in = XW'(c6_ff) <<< (30 - A);
      vy_in = signed'(XW'(root_ff[S])) <<< (30 - A);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         if (vx_in < 0) begin
            vx_ff[0] <= vy_in;
            vy_ff[0] <= -vx_in;
            vz_ff[0] <= ZW'(90 * gcd_pkg::Z_DEG);
         end else begin
            vx_ff[0] <= vx_in;
            vy_ff[0] <= vy_in;
            vz_ff[0] <= '0;
         end
         vs_ff[0] <= (root_ff[S] == '0);
         vp_ff[0] <= (c6_ff > 0);
      end
   end
   for (genvar k = 0; k < N; k++) begin : g_vec
      localparam logic signed [ZW-1:0] ATAN = ZW'(gcd_pkg::atan_deg(5'(k)));
      always_ff @(posedge clock) begin
         if (en) begin
            if (vy_ff[k] > 0) begin
               vx_ff[k+1] <= vx_ff[k] + (vy_ff[k] >>> k);
               vy_ff[k+1] <= vy_ff[k] - (vx_ff[k] >>> k);
               vz_ff[k+1] <= vz_ff[k] + ATAN;
            end else begin
               vx_ff[k+1] <= vx_ff[k] - (vy_ff[k] >>> k);
               vy_ff[k+1] <= vy_ff[k] + (vx_ff[k] >>> k);
               vz_ff[k+1] <= vz_ff[k] - ATAN;
            end
            vs_ff[k+1] <= vs_ff[k];
            vp_ff[k+1] <= vp_ff[k];
         end
      end
   end

   // ---- clamp angle to [0, 180] degrees, exact ends when s is zero
   localparam logic signed [ZW-1:0] Z180 = ZW'(180 * gcd_pkg::Z_DEG);
   logic signed [ZW-1:0] zf_in;
   logic [31:0]          zf_ff;
   always_comb begin
      zf_in = vz_ff[N];
      if (vs_ff[N]) begin
         zf_in = vp_ff[N] ? '0 : Z180;
      end else if (vz_ff[N] < 0) begin
         zf_in = '0;
      end else if (vz_ff[N] > Z180) begin
         zf_in = Z180;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff <= zf_in[31:0];
      end
   end

   // ---- distance = angle * 60, rounded, saturated
   logic [DW-1:0] d_in;
   logic [21:0]   dist_ff;
   always_comb begin
      d_in = ((DW'(zf_ff) << 6) - (DW'(zf_ff) << 2) + (DW'(1) << (23 - DIST_FRAC_BITS)))
             >> (24 - DIST_FRAC_BITS);
      if (d_in > DW'(gcd_pkg::OUT_MAX)) begin
         d_in = DW'(gcd_pkg::OUT_MAX);
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff <= d_in[21:0];
      end
   end
   assign rsp_dist_nm = dist_ff;

endmodule
